// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the next clock edge, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/f32am_pkg.sv -----
// Package for the single-precision add/multiply pipeline.
// Holds format constants and stage types; depends on nothing.
`timescale 1ns / 1ps

package f32am_pkg;

  localparam int unsigned FracBits = 23;
  localparam int unsigned MantBits = FracBits + 1;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned ExpW     = 11;
  localparam int unsigned SumW     = 57;
  localparam int unsigned LzcW     = 6;
  localparam logic [ExpBits-1:0] ExpMax = 8'hFF;
  localparam logic signed [ExpW-1:0] ExpBias = 11'sd127;

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_MUL = 1'b1
  } func_t;

  typedef struct packed {
    logic                   func;
    logic                   sign;
    logic                   special;
    logic [31:0]            spec_val;
    logic signed [ExpW-1:0] exp;
    logic [MantBits-1:0]    m_big;
    logic [MantBits-1:0]    m_small;
    logic [ExpBits-1:0]     shamt;
    logic                   sub;
    logic [2*MantBits-1:0]  prod;
  } s1_t;

  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic [31:0]            spec_val;
    logic signed [ExpW-1:0] exp;
    logic [SumW-1:0]        sum;
  } s2_t;

  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic [31:0]            spec_val;
    logic signed [ExpW-1:0] exp;
    logic [SumW-1:0]        sum;
    logic [LzcW-1:0]        lzc;
    logic                   zero;
  } s3_t;

endpackage

// ----- hdl/float32_add_multiply_top.sv -----
// Path: an accepted request is registered in s1_r, s2_r and s3_r in turn, then
// in out_result_r, from which it can be taken on out_valid.
// Throughput: one request per cycle; the whole pipe advances whenever the
// output register is empty or being taken, so in_ready follows out_ready.
// Stages: unpack/swap/multiply, align/add, leading-zero count, normalize/pack.
// Reset: synchronous active-low rst_n clears all stage valid bits only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module float32_add_multiply_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result
);

  localparam int unsigned MB = f32am_pkg::MantBits;
  localparam int unsigned FB = f32am_pkg::FracBits;
  localparam int unsigned SW = f32am_pkg::SumW;

  // Stage valid bits and payload registers.
  logic v1_r, v2_r, v3_r, out_valid_r;
  f32am_pkg::s1_t s1_r, s1_nxt;
  f32am_pkg::s2_t s2_r, s2_nxt;
  f32am_pkg::s3_t s3_r, s3_nxt;
  logic [31:0] out_result_r, out_result_nxt;
  logic advance;

  // Advance every stage together when the output register can take a request.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

  // Stage 1: unpack, order addends by magnitude, multiply significands.
  logic                sa, sb;
  logic [7:0]          ea, eb;
  logic [MB-1:0]       ma, mb;
  logic                za, zb, swap;
  logic [31:0]         pass_a, pass_b;

  always_comb begin
    sa = in_operand_a[31];
    sb = in_operand_b[31];
    ea = in_operand_a[30:23];
    eb = in_operand_b[30:23];
    ma = {1'b1, in_operand_a[FB-1:0]};
    mb = {1'b1, in_operand_b[FB-1:0]};
    za = (ea == 8'd0);
    zb = (eb == 8'd0);
    swap = ({eb, mb} > {ea, ma});
    // A lone nonzero addend repacks as itself; top exponent saturates.
    pass_a = (ea == f32am_pkg::ExpMax) ? {sa, f32am_pkg::ExpMax, 23'd0} : in_operand_a;
    pass_b = (eb == f32am_pkg::ExpMax) ? {sb, f32am_pkg::ExpMax, 23'd0} : in_operand_b;

    s1_nxt.func     = in_func;
    s1_nxt.sub      = sa ^ sb;
    s1_nxt.prod     = ma * mb;
    s1_nxt.m_big    = swap ? mb : ma;
    s1_nxt.m_small  = swap ? ma : mb;
    s1_nxt.shamt    = swap ? (eb - ea) : (ea - eb);
    if (in_func == f32am_pkg::FUNC_MUL) begin
      s1_nxt.sign     = sa ^ sb;
      s1_nxt.exp      = $signed({3'b000, ea}) + $signed({3'b000, eb}) - f32am_pkg::ExpBias;
      s1_nxt.special  = za || zb;
      s1_nxt.spec_val = {sa ^ sb, 31'd0};
    end else begin
      s1_nxt.sign     = swap ? sb : sa;
      s1_nxt.exp      = $signed({3'b000, (swap ? eb : ea)});
      s1_nxt.special  = za || zb;
      if (za && zb) begin
        s1_nxt.spec_val = {sa & sb, 31'd0};
      end else if (za) begin
        s1_nxt.spec_val = pass_b;
      end else begin
        s1_nxt.spec_val = pass_a;
      end
    end
  end

  // Stage 2: align the smaller addend, fold lost bits into a borrow, add or subtract; or place the product.
  logic [SW-1:0] big_w, small_w;
  logic [MB-1:0] lost_w;
  logic [7:0]    lsh_w;
  logic          sticky;

  always_comb begin
    big_w   = {1'b0, s1_r.m_big, 32'd0};
    small_w = (s1_r.shamt >= 8'd56) ? '0 : ({1'b0, s1_r.m_small, 32'd0} >> s1_r.shamt);
    lsh_w   = 8'd56 - s1_r.shamt;
    lost_w  = s1_r.m_small << lsh_w[4:0];
    if (s1_r.shamt >= 8'd56) begin
      sticky = 1'b1;
    end else if (s1_r.shamt > 8'd32) begin
      sticky = (lost_w != '0);
    end else begin
      sticky = 1'b0;
    end

    s2_nxt.sign     = s1_r.sign;
    s2_nxt.special  = s1_r.special;
    s2_nxt.spec_val = s1_r.spec_val;
    s2_nxt.exp      = s1_r.exp;
    if (s1_r.func == f32am_pkg::FUNC_MUL) begin
      s2_nxt.sum = {s1_r.prod, 9'd0};
    end else if (s1_r.sub) begin
      s2_nxt.sum = big_w - small_w - {{(SW-1){1'b0}}, sticky};
    end else begin
      s2_nxt.sum = big_w + small_w;
    end
  end

  // Stage 3: count leading zeros of the exact magnitude.
  always_comb begin
    s3_nxt.sign     = s2_r.sign;
    s3_nxt.special  = s2_r.special;
    s3_nxt.spec_val = s2_r.spec_val;
    s3_nxt.exp      = s2_r.exp;
    s3_nxt.sum      = s2_r.sum;
    s3_nxt.zero     = (s2_r.sum == '0);
    s3_nxt.lzc      = '0;
    for (int i = 0; i < SW; i++) begin
      if (s2_r.sum[i]) begin
        s3_nxt.lzc = 6'(SW - 1 - i);
      end
    end
  end

  // Stage 4: normalize, truncate, and pack with saturation and flush.
  logic [SW-1:0]                      norm_w;
  logic signed [f32am_pkg::ExpW-1:0]  exp_w;

  always_comb begin
    norm_w = s3_r.sum << s3_r.lzc;
    exp_w  = s3_r.exp + 11'sd1 - $signed({5'b00000, s3_r.lzc});
    if (s3_r.special) begin
      out_result_nxt = s3_r.spec_val;
    end else if (s3_r.zero) begin
      out_result_nxt = 32'd0;
    end else if (exp_w >= 11'sd255) begin
      out_result_nxt = {s3_r.sign, f32am_pkg::ExpMax, 23'd0};
    end else if (exp_w <= 11'sd0) begin
      out_result_nxt = {s3_r.sign, 31'd0};
    end else begin
      out_result_nxt = {s3_r.sign, exp_w[7:0], norm_w[SW-2 -: FB]};
    end
  end

  // Valid bits: clear on reset, advance with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Payload: hold on stall, no reset needed.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r         <= s1_nxt;
      s2_r         <= s2_nxt;
      s3_r         <= s3_nxt;
      out_result_r <= out_result_nxt;
    end
  end

  // A request in stage 1 reaches stage 2 on the next advance.
  `ASSERT_NEXT(a_s1_to_s2, clk, rst_n, v1_r && advance, v2_r)
  // The last stage feeds the output register on advance.
  `ASSERT_NEXT(a_s3_to_out, clk, rst_n, v3_r && advance, out_valid_r)
  // Special-case results pass untouched to the output.
  `ASSERT_NEXT(a_special, clk, rst_n, v3_r && advance && s3_r.special,
               out_result_r == $past(s3_r.spec_val))

endmodule
